// ===== rtl/static_linked_list_manager_defines.svh =====
// assertion macros for the static linked list manager checker
`ifndef STATIC_LINKED_LIST_MANAGER_DEFINES_SVH
`define STATIC_LINKED_LIST_MANAGER_DEFINES_SVH

// checked while out of reset
`define SLLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SLLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/sllm_pkg.sv =====
package sllm_pkg;

   localparam int SLOTS_DEFAULT = 128;
   localparam int POS_W         = 8;
   localparam int VALUE_W       = 32;
   localparam int LEN_W         = 8;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/sllm_req_if.sv =====
interface sllm_req_if;
   import sllm_pkg::*;

   logic                       valid;
   logic                       ready;
   func_type                   func;
   logic [POS_W-1:0]           position;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, func, position, value, input ready);
   modport sink (input valid, func, position, value, output ready);
endinterface

// ===== rtl/sllm_rsp_if.sv =====
interface sllm_rsp_if;
   import sllm_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   logic [LEN_W-1:0] length;

   modport source (output valid, status, length, input ready);
   modport sink (input valid, status, length, output ready);
endinterface

// ===== rtl/sllm_store.sv =====
module sllm_store #(
   parameter int SLOTS = sllm_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(SLOTS),
   parameter int LW    = $clog2(SLOTS + 1)
) (
   input  logic                          clock,
   input  logic                          next_we,
   input  logic [AW-1:0]                 next_waddr,
   input  logic [LW-1:0]                 next_wdata,
   input  logic [AW-1:0]                 next_raddr,
   output logic [LW-1:0]                 next_rdata,
   input  logic                          value_we,
   input  logic [AW-1:0]                 value_waddr,
   input  logic [sllm_pkg::VALUE_W-1:0]  value_wdata
);
   import sllm_pkg::*;

   logic [LW-1:0]      next_mem [SLOTS];
   logic [VALUE_W-1:0] value_mem [SLOTS];
   logic [LW-1:0]      next_rdata_ff;

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rdata_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
   end

   assign next_rdata = next_rdata_ff;

endmodule

// ===== rtl/static_linked_list_manager.sv =====
// Array-based singly linked list with a free list over SLOTS slots. Insert puts a value
// before a one-based position (1..length, or 1 on an empty list); delete removes the
// element at a position and returns its slot to the front of the free list. Every request
// beat gives one response beat with a status and the list length after the operation.
// After reset the block runs a clearing pass that chains the link memory;
// req_bus.ready stays low during it. The walk to the predecessor follows one link per
// cycle through the single read port of the link memory. One item is in work at a time;
// a finished response waits in an output register while the next request is taken.
module static_linked_list_manager #(
   parameter int SLOTS = sllm_pkg::SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sllm_req_if.sink   req_bus,
   sllm_rsp_if.source rsp_bus
);
   import sllm_pkg::*;

   localparam int AW   = $clog2(SLOTS);
   localparam int LW   = $clog2(SLOTS + 1);
   localparam int CMPW = (LW > POS_W) ? LW : POS_W;
   localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   typedef enum logic [8:0] {
      ST_INIT      = 9'b000000001,
      ST_IDLE      = 9'b000000010,
      ST_ALLOC     = 9'b000000100,
      ST_WALK      = 9'b000001000,
      ST_SPLICE    = 9'b000010000,
      ST_DROP_HEAD = 9'b000100000,
      ST_UNLINK    = 9'b001000000,
      ST_RELEASE   = 9'b010000000,
      ST_RESP      = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      init_ff, init_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      free_ff, free_in;
   logic [LW-1:0]      count_ff, count_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      slot_ff, slot_in;
   logic [POS_W-1:0]   steps_ff, steps_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   func_type           func_ff, func_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   logic               next_we;
   logic [AW-1:0]      next_waddr;
   logic [LW-1:0]      next_wdata;
   logic [AW-1:0]      next_raddr;
   logic [LW-1:0]      next_rdata;
   logic               value_we;

   logic [CMPW-1:0]    pos_ext, count_ext;
   logic               pos_zero, pos_over, pos_one, list_empty;
   logic               ins_bad, del_bad, pool_empty, req_beat, rsp_free;

   sllm_store #(.SLOTS(SLOTS), .AW(AW), .LW(LW)) u_store (
      .clock       (clock),
      .next_we     (next_we),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .next_raddr  (next_raddr),
      .next_rdata  (next_rdata),
      .value_we    (value_we),
      .value_waddr (slot_ff[AW-1:0]),
      .value_wdata (value_ff)
   );

   assign pos_ext    = CMPW'(req_bus.position);
   assign count_ext  = CMPW'(count_ff);
   assign pos_zero   = (req_bus.position == '0);
   assign pos_one    = (req_bus.position == POS_W'(1));
   assign pos_over   = (pos_ext > count_ext);
   assign list_empty = (count_ff == '0);
   assign del_bad    = pos_zero || pos_over;
   assign ins_bad    = pos_zero || (pos_over && !(list_empty && pos_one));
   assign pool_empty = (free_ff == LINK_NULL);

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign req_beat       = req_bus.valid && req_bus.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.length = rsp_length_ff;

   // read port: free head or list head while idle, list head in alloc, otherwise follow the last link read
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  next_raddr = (req_bus.func == FUNC_DELETE) ? head_ff[AW-1:0]
                                                              : free_ff[AW-1:0];
         ST_ALLOC: next_raddr = head_ff[AW-1:0];
         default:  next_raddr = next_rdata[AW-1:0];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      steps_in      = steps_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      func_in       = func_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      next_we       = 1'b0;
      next_waddr    = slot_ff[AW-1:0];
      next_wdata    = next_rdata;
      value_we      = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            next_we    = 1'b1;
            next_waddr = init_ff;
            next_wdata = LW'(init_ff) + LW'(1);
            init_in    = init_ff + AW'(1);
            if (init_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               func_in   = req_bus.func;
               pos_in    = req_bus.position;
               value_in  = req_bus.value;
               status_in = STATUS_DONE;
               if (req_bus.func == FUNC_INSERT) begin
                  slot_in = free_ff;
                  if (ins_bad) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_RESP;
                  end else if (pool_empty) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_ALLOC;
                  end
               end else begin
                  slot_in  = head_ff;
                  cur_in   = head_ff;
                  steps_in = req_bus.position - POS_W'(2);
                  if (del_bad) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_RESP;
                  end else if (pos_one) begin
                     state_in = ST_DROP_HEAD;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_ALLOC: begin
            free_in  = next_rdata;
            value_we = 1'b1;
            if (pos_ff == POS_W'(1)) begin
               next_we    = 1'b1;
               next_wdata = head_ff;
               head_in    = slot_ff;
               count_in   = count_ff + LW'(1);
               state_in   = ST_RESP;
            end else begin
               cur_in   = head_ff;
               steps_in = pos_ff - POS_W'(2);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (steps_ff == '0) begin
               if (func_ff == FUNC_INSERT) begin
                  next_we  = 1'b1;
                  state_in = ST_SPLICE;
               end else begin
                  slot_in  = next_rdata;
                  state_in = ST_UNLINK;
               end
            end else begin
               cur_in   = next_rdata;
               steps_in = steps_ff - POS_W'(1);
            end
         end
         ST_SPLICE: begin
            next_we    = 1'b1;
            next_waddr = cur_ff[AW-1:0];
            next_wdata = slot_ff;
            count_in   = count_ff + LW'(1);
            state_in   = ST_RESP;
         end
         ST_DROP_HEAD: begin
            head_in  = next_rdata;
            state_in = ST_RELEASE;
         end
         ST_UNLINK: begin
            next_we    = 1'b1;
            next_waddr = cur_ff[AW-1:0];
            state_in   = ST_RELEASE;
         end
         ST_RELEASE: begin
            next_we    = 1'b1;
            next_wdata = free_ff;
            free_in    = slot_ff;
            count_in   = count_ff - LW'(1);
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = count_ext[LEN_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         head_ff      <= LINK_NULL;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      slot_ff       <= slot_in;
      steps_ff      <= steps_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      func_ff       <= func_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

endmodule

// ===== rtl/sllm_checker.sv =====
`include "static_linked_list_manager_defines.svh"

module sllm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready
);

   logic       req_beat, rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // items taken whose response beat has not gone out yet
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `SLLM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response beat dropped")
   `SLLM_ASSERT(a_no_extra_rsp, rsp_valid |-> pending_ff != 2'd0, "response without request")
   `SLLM_ASSERT(a_pending_bound, pending_ff != 2'd3, "too many items in flight")
   `SLLM_ASSERT(a_one_at_a_time, req_beat |=> !req_ready, "request taken while busy")
   `SLLM_ASSERT_ALWAYS(a_init_pass, reset |=> !req_ready, "ready during clearing pass")

endmodule

bind static_linked_list_manager sllm_checker u_sllm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready)
);
